>>> hdl/assert_macros.svh
// assertion macros shared by the classifier rtl
// each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, quiet during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/phc_pkg.sv
// types and constants of the packet header classifier
// used by phc_front, phc_queue, phc_back and packet_header_classifier
package phc_pkg;

    // input item
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] frame_byte;
        logic       frame_end;
        logic [3:0] counter_select;
    } t_in_item;

    // result item
    typedef struct packed {
        logic        result_kind;
        logic [2:0]  network_class;
        logic [2:0]  transport_class;
        logic [2:0]  application_class;
        logic        ip_length_bad;
        logic        tcp_offset_bad;
        logic        truncated;
        logic [15:0] destination_port;
        logic [31:0] counter_value;
    } t_out_item;

    // commands passed from the front to the back
    typedef enum logic [1:0] {
        CMD_SUMMARY,
        CMD_READ,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic       count_net;
        t_out_item  summary;
        logic [3:0] sel;
    } t_cmd;

    // queue status seen by the top and the back
    typedef struct packed {
        logic head_valid;
        logic full;
    } t_q_status;

    // function codes
    localparam logic [1:0] FUNC_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // result kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_WEB_PORT  = 2'd0;
    localparam logic [1:0] CFG_FTP_PORT  = 2'd1;
    localparam logic [1:0] CFG_SSH_PORT  = 2'd2;

    localparam logic [15:0] WEB_PORT_RST = 16'd80;
    localparam logic [15:0] FTP_PORT_RST = 16'd21;
    localparam logic [15:0] SSH_PORT_RST = 16'd22;

    // network classes
    localparam logic [2:0] NET_ARP   = 3'd0;
    localparam logic [2:0] NET_RARP  = 3'd1;
    localparam logic [2:0] NET_IPV6  = 3'd2;
    localparam logic [2:0] NET_IPV4  = 3'd3;
    localparam logic [2:0] NET_OTHER = 3'd4;

    // transport classes
    localparam logic [2:0] TRSP_NONE  = 3'd0;
    localparam logic [2:0] TRSP_ICMP  = 3'd1;
    localparam logic [2:0] TRSP_TCP   = 3'd2;
    localparam logic [2:0] TRSP_UDP   = 3'd3;
    localparam logic [2:0] TRSP_OTHER = 3'd4;

    // application classes
    localparam logic [2:0] APP_NONE  = 3'd0;
    localparam logic [2:0] APP_HTTP  = 3'd1;
    localparam logic [2:0] APP_FTP   = 3'd2;
    localparam logic [2:0] APP_SSH   = 3'd3;
    localparam logic [2:0] APP_OTHER = 3'd4;

    // ethertypes and ip protocols
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_RARP = 16'h8035;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    // header geometry
    localparam logic [6:0] OFS_ETYPE_HI = 7'd12;
    localparam logic [6:0] OFS_ETYPE_LO = 7'd13;
    localparam logic [6:0] OFS_IP_VHL   = 7'd14;
    localparam logic [6:0] OFS_IP_PROTO = 7'd23;
    localparam logic [6:0] OFS_MAX      = 7'd127;
    localparam logic [7:0] ETH_HDR      = 8'd14;
    localparam logic [5:0] MIN_HDR      = 6'd20;
    localparam logic [7:0] TCP_PORT_HI  = 8'd2;
    localparam logic [7:0] TCP_PORT_LO  = 8'd3;
    localparam logic [7:0] TCP_OFFSET   = 8'd12;

    // counter map
    localparam int          N_COUNTERS    = 13;
    localparam logic [3:0]  CNT_TRSP_BASE = 4'd4;
    localparam logic [3:0]  CNT_APP_BASE  = 4'd8;

endpackage

>>> hdl/phc_front.sv
// front end of the classifier: byte parser, frame classifier, port registers
// depends on phc_pkg
module phc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  phc_pkg::t_in_item i_item,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    output logic             o_push,
    output phc_pkg::t_cmd    o_cmd
);

    // port registers
    logic [15:0] r_web_port, r_ftp_port, r_ssh_port;

    // per-frame captures
    logic [6:0]  r_byte_offset, n_byte_offset;
    logic [15:0] r_ether_kind, n_ether_kind;
    logic [5:0]  r_ip_hdr_bytes, n_ip_hdr_bytes;
    logic [7:0]  r_ip_proto, n_ip_proto;
    logic [15:0] r_tcp_port, n_tcp_port;
    logic [5:0]  r_tcp_hdr_bytes, n_tcp_hdr_bytes;

    logic [7:0]  w_pos;
    logic [7:0]  w_tcp_base;
    logic [7:0]  w_count;
    logic [7:0]  w_end_base;
    logic        w_byte;
    phc_pkg::t_out_item w_sum;
    logic        w_count_net;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_web_port <= phc_pkg::WEB_PORT_RST;
            r_ftp_port <= phc_pkg::FTP_PORT_RST;
            r_ssh_port <= phc_pkg::SSH_PORT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                phc_pkg::CFG_WEB_PORT: r_web_port <= i_cfg_data;
                phc_pkg::CFG_FTP_PORT: r_ftp_port <= i_cfg_data;
                phc_pkg::CFG_SSH_PORT: r_ssh_port <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_byte     = i_accept && (i_item.func == phc_pkg::FUNC_BYTE);
    assign w_pos      = {1'b0, r_byte_offset};
    assign w_tcp_base = phc_pkg::ETH_HDR + {2'b00, r_ip_hdr_bytes};

    // field capture for the current byte
    always_comb begin
        n_ether_kind    = r_ether_kind;
        n_ip_hdr_bytes  = r_ip_hdr_bytes;
        n_ip_proto      = r_ip_proto;
        n_tcp_port      = r_tcp_port;
        n_tcp_hdr_bytes = r_tcp_hdr_bytes;
        if (r_byte_offset == phc_pkg::OFS_ETYPE_HI) begin
            n_ether_kind = {i_item.frame_byte, r_ether_kind[7:0]};
        end else if (r_byte_offset == phc_pkg::OFS_ETYPE_LO) begin
            n_ether_kind = {r_ether_kind[15:8], i_item.frame_byte};
        end else if (r_ether_kind == phc_pkg::ETYPE_IPV4) begin
            if (r_byte_offset == phc_pkg::OFS_IP_VHL) begin
                n_ip_hdr_bytes = {i_item.frame_byte[3:0], 2'b00};
            end else if (r_byte_offset == phc_pkg::OFS_IP_PROTO) begin
                n_ip_proto = i_item.frame_byte;
            end else if (r_ip_hdr_bytes >= phc_pkg::MIN_HDR &&
                         r_ip_proto == phc_pkg::PROTO_TCP) begin
                if (w_pos == w_tcp_base + phc_pkg::TCP_PORT_HI) begin
                    n_tcp_port = {i_item.frame_byte, r_tcp_port[7:0]};
                end else if (w_pos == w_tcp_base + phc_pkg::TCP_PORT_LO) begin
                    n_tcp_port = {r_tcp_port[15:8], i_item.frame_byte};
                end else if (w_pos == w_tcp_base + phc_pkg::TCP_OFFSET) begin
                    n_tcp_hdr_bytes = {i_item.frame_byte[7:4], 2'b00};
                end
            end
        end
        n_byte_offset = (r_byte_offset != phc_pkg::OFS_MAX) ? r_byte_offset + 7'd1
                                                            : r_byte_offset;
    end

    assign w_count    = w_pos + 8'd1;
    assign w_end_base = phc_pkg::ETH_HDR + {2'b00, n_ip_hdr_bytes};

    // classification of a frame on its last byte
    always_comb begin
        w_sum             = '0;
        w_sum.result_kind = phc_pkg::KIND_SUMMARY;
        w_sum.network_class = phc_pkg::NET_OTHER;
        w_count_net       = 1'b0;
        if (w_count < phc_pkg::ETH_HDR) begin
            w_sum.truncated = 1'b1;
        end else begin
            w_count_net = 1'b1;
            case (n_ether_kind)
                phc_pkg::ETYPE_ARP:  w_sum.network_class = phc_pkg::NET_ARP;
                phc_pkg::ETYPE_RARP: w_sum.network_class = phc_pkg::NET_RARP;
                phc_pkg::ETYPE_IPV6: w_sum.network_class = phc_pkg::NET_IPV6;
                phc_pkg::ETYPE_IPV4: w_sum.network_class = phc_pkg::NET_IPV4;
                default:             w_sum.network_class = phc_pkg::NET_OTHER;
            endcase
            if (w_sum.network_class == phc_pkg::NET_IPV4) begin
                if (w_count < phc_pkg::ETH_HDR + 8'd1) begin
                    w_sum.truncated = 1'b1;
                end else if (n_ip_hdr_bytes < phc_pkg::MIN_HDR) begin
                    w_sum.ip_length_bad = 1'b1;
                end else if (w_count < phc_pkg::ETH_HDR + 8'd10) begin
                    w_sum.truncated = 1'b1;
                end else begin
                    case (n_ip_proto)
                        phc_pkg::PROTO_ICMP: w_sum.transport_class = phc_pkg::TRSP_ICMP;
                        phc_pkg::PROTO_TCP:  w_sum.transport_class = phc_pkg::TRSP_TCP;
                        phc_pkg::PROTO_UDP:  w_sum.transport_class = phc_pkg::TRSP_UDP;
                        default:             w_sum.transport_class = phc_pkg::TRSP_OTHER;
                    endcase
                    if (w_sum.transport_class == phc_pkg::TRSP_TCP) begin
                        w_sum.destination_port = n_tcp_port;
                        if (w_count < w_end_base + 8'd13) begin
                            w_sum.truncated = 1'b1;
                        end else if (n_tcp_hdr_bytes < phc_pkg::MIN_HDR) begin
                            w_sum.tcp_offset_bad = 1'b1;
                        end else if (n_tcp_port == r_web_port) begin
                            w_sum.application_class = phc_pkg::APP_HTTP;
                        end else if (n_tcp_port == r_ftp_port) begin
                            w_sum.application_class = phc_pkg::APP_FTP;
                        end else if (n_tcp_port == r_ssh_port) begin
                            w_sum.application_class = phc_pkg::APP_SSH;
                        end else begin
                            w_sum.application_class = phc_pkg::APP_OTHER;
                        end
                    end
                end
            end
        end
    end

    // frame state update, cleared after each last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset   <= '0;
            r_ether_kind    <= '0;
            r_ip_hdr_bytes  <= '0;
            r_ip_proto      <= '0;
            r_tcp_port      <= '0;
            r_tcp_hdr_bytes <= '0;
        end else if (w_byte) begin
            if (i_item.frame_end) begin
                r_byte_offset   <= '0;
                r_ether_kind    <= '0;
                r_ip_hdr_bytes  <= '0;
                r_ip_proto      <= '0;
                r_tcp_port      <= '0;
                r_tcp_hdr_bytes <= '0;
            end else begin
                r_byte_offset   <= n_byte_offset;
                r_ether_kind    <= n_ether_kind;
                r_ip_hdr_bytes  <= n_ip_hdr_bytes;
                r_ip_proto      <= n_ip_proto;
                r_tcp_port      <= n_tcp_port;
                r_tcp_hdr_bytes <= n_tcp_hdr_bytes;
            end
        end
    end

    // command to the back end
    always_comb begin
        o_push          = 1'b0;
        o_cmd.kind      = phc_pkg::CMD_SUMMARY;
        o_cmd.count_net = w_count_net;
        o_cmd.summary   = w_sum;
        o_cmd.sel       = i_item.counter_select;
        if (i_accept) begin
            case (i_item.func)
                phc_pkg::FUNC_BYTE: begin
                    o_push     = i_item.frame_end;
                    o_cmd.kind = phc_pkg::CMD_SUMMARY;
                end
                phc_pkg::FUNC_READ: begin
                    o_push     = 1'b1;
                    o_cmd.kind = phc_pkg::CMD_READ;
                end
                phc_pkg::FUNC_CLEAR: begin
                    o_push     = 1'b1;
                    o_cmd.kind = phc_pkg::CMD_CLEAR;
                end
                default: o_push = 1'b0;
            endcase
        end
    end

endmodule

>>> hdl/phc_queue.sv
// two-entry command queue between the front and the back of the classifier
// depends on phc_pkg
module phc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  phc_pkg::t_cmd       i_cmd,
    input  logic                i_pop,
    output phc_pkg::t_cmd       o_head,
    output phc_pkg::t_q_status  o_status
);

    // slot 0 is always the head
    phc_pkg::t_cmd r_slot0, r_slot1, n_slot0, n_slot1;
    logic          r_v0, r_v1, n_v0, n_v1;

    // shift on pop, then fill the first free slot
    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_v0    = r_v0;
        n_v1    = r_v1;
        if (i_pop) begin
            n_slot0 = r_slot1;
            n_v0    = r_v1;
            n_v1    = 1'b0;
        end
        if (i_push) begin
            if (!n_v0) begin
                n_slot0 = i_cmd;
                n_v0    = 1'b1;
            end else begin
                n_slot1 = i_cmd;
                n_v1    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_head              = r_slot0;
    assign o_status.head_valid = r_v0;
    assign o_status.full       = r_v1;

endmodule

>>> hdl/phc_back.sv
// back end of the classifier: class counters, reads, clears and the result register
// depends on phc_pkg
module phc_back #(
    parameter int COUNT_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  phc_pkg::t_cmd       i_head,
    input  phc_pkg::t_q_status  i_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output phc_pkg::t_out_item  o_out_item
);

    localparam int READ_BITS = (COUNT_BITS < 32) ? COUNT_BITS : 32;

    logic [COUNT_BITS-1:0] r_counters [phc_pkg::N_COUNTERS];
    logic                  r_out_valid;
    phc_pkg::t_out_item    r_out_item, w_read_item;
    logic                  w_take;
    logic [3:0]            w_net_idx, w_trsp_idx, w_app_idx;
    logic [COUNT_BITS-1:0] w_sel_cnt;

    // the result register can take a new item when empty or being drained
    assign w_take = !r_out_valid || !i_out_stall;
    assign o_pop  = i_status.head_valid && w_take;

    assign w_net_idx  = {1'b0, i_head.summary.network_class};
    assign w_trsp_idx = phc_pkg::CNT_TRSP_BASE + {1'b0, i_head.summary.transport_class};
    assign w_app_idx  = phc_pkg::CNT_APP_BASE + {1'b0, i_head.summary.application_class};

    // counter bumps and clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < phc_pkg::N_COUNTERS; i++) begin
                r_counters[i] <= '0;
            end
        end else if (o_pop) begin
            if (i_head.kind == phc_pkg::CMD_CLEAR) begin
                for (int i = 0; i < phc_pkg::N_COUNTERS; i++) begin
                    r_counters[i] <= '0;
                end
            end else if (i_head.kind == phc_pkg::CMD_SUMMARY) begin
                for (int i = 0; i < phc_pkg::N_COUNTERS; i++) begin
                    if ((i_head.count_net && w_net_idx == 4'(i)) ||
                        (i_head.summary.transport_class != phc_pkg::TRSP_NONE &&
                         w_trsp_idx == 4'(i)) ||
                        (i_head.summary.application_class != phc_pkg::APP_NONE &&
                         w_app_idx == 4'(i))) begin
                        r_counters[i] <= r_counters[i] + COUNT_BITS'(1);
                    end
                end
            end
        end
    end

    // counter read data
    always_comb begin
        w_sel_cnt = '0;
        if (i_head.sel < 4'(phc_pkg::N_COUNTERS)) begin
            w_sel_cnt = r_counters[i_head.sel];
        end
        w_read_item               = '0;
        w_read_item.result_kind   = phc_pkg::KIND_READ;
        w_read_item.counter_value = 32'(w_sel_cnt[READ_BITS-1:0]);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_head.kind != phc_pkg::CMD_CLEAR) begin
            r_out_valid <= 1'b1;
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            case (i_head.kind)
                phc_pkg::CMD_SUMMARY: r_out_item <= i_head.summary;
                phc_pkg::CMD_READ:    r_out_item <= w_read_item;
                default:              r_out_item <= r_out_item;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> hdl/packet_header_classifier.sv
// Ethernet / IPv4 / TCP header classifier with per-class counters
// Input channel: one item per cycle with valid/stall; func selects frame byte,
// counter read or clear of all counters. Bytes start at the Ethernet header.
// Output channel: one result per frame (on its last byte) and per counter read;
// clears and non-final bytes give no result. Results keep input order.
// Path: the front classifies combinationally, the command is written to the queue
// at the accepting edge and is then popped into the result register once that
// register is empty or being drained (front classify -> queue -> result).
// Throughput: one item per cycle unless the input stalls; the front parses and
// classifies bytes combinationally; the back bumps up to three counters at once.
// A two-entry command queue sits between the two halves; when the receiver
// stalls, the queue fills and the input stall rises, the held result stays put.
// Reset (synchronous, active low) clears frame state and counters, empties the
// queue and the result register and loads ports 80, 21 and 22. Configuration
// writes take effect in the cycle after the write enable.
// depends on phc_pkg, phc_front, phc_queue, phc_back and assert_macros.svh
`include "assert_macros.svh"

module packet_header_classifier #(
    parameter int COUNT_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  phc_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output phc_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    logic               w_accept;
    logic               w_push;
    logic               w_pop;
    phc_pkg::t_cmd      w_cmd;
    phc_pkg::t_cmd      w_head;
    phc_pkg::t_q_status w_qstat;
    logic               w_out_is_read;
    logic               w_read_clean;
    logic               w_out_has_trsp;
    logic               w_trsp_clean;

    // input handshake
    assign o_in_stall = w_qstat.full;
    assign w_accept   = i_in_valid && !w_qstat.full;

    phc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (w_push),
        .o_cmd       (w_cmd)
    );

    phc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_qstat)
    );

    phc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_status    (w_qstat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // terms used by the checks
    assign w_out_is_read  = o_out_valid && (o_out_item.result_kind == phc_pkg::KIND_READ);
    assign w_read_clean   = (o_out_item.network_class == phc_pkg::NET_ARP) &&
                            (o_out_item.destination_port == 16'd0);
    assign w_out_has_trsp = o_out_valid &&
                            (o_out_item.result_kind == phc_pkg::KIND_SUMMARY) &&
                            (o_out_item.transport_class != phc_pkg::TRSP_NONE);
    assign w_trsp_clean   = (o_out_item.network_class == phc_pkg::NET_IPV4) &&
                            (o_out_item.counter_value == 32'd0);

    // checks
    `ASSERT_IMPL(a_no_push_when_full, w_push, !w_qstat.full)
    `ASSERT_NEXT(a_pop_empties_full, w_pop && !w_push && w_qstat.full, !w_qstat.full)
    `ASSERT_IMPL(a_read_fields_zero, w_out_is_read, w_read_clean)
    `ASSERT_IMPL(a_transport_needs_ipv4, w_out_has_trsp, w_trsp_clean)

endmodule
